// ----- sv/pcet_pkg.sv -----
package pcet_pkg;

  localparam int unsigned AdcW  = 12;
  localparam int unsigned MaW   = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned SumW  = 48;
  localparam int unsigned StW   = 2;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  // input word: opcode, adc_value, current_ma, total_volume, time_ms
  localparam int unsigned InFieldsW = 1 + AdcW + MaW + WordW + WordW;
  localparam int unsigned InW       = ((InFieldsW + 7) / 8) * 8;
  // output word: pump_state, event_active, event_done, duration, volume, peak, avg
  localparam int unsigned OutFieldsW = StW + 1 + 1 + WordW + WordW + MaW + MaW;
  localparam int unsigned OutW       = ((OutFieldsW + 7) / 8) * 8;

  typedef enum logic [IdxW-1:0] {
    REG_ADC_THR  = 2'd0,
    REG_RUN_LVL  = 2'd1,
    REG_STBY_LVL = 2'd2
  } reg_idx_e;

  localparam logic [AdcW-1:0] AdcThrRst  = 12'd2048;
  localparam logic [MaW-1:0]  RunLvlRst  = 16'd1000;
  localparam logic [MaW-1:0]  StbyLvlRst = 16'd100;

  localparam logic [StW-1:0] PS_OFF     = 2'd0;
  localparam logic [StW-1:0] PS_STANDBY = 2'd1;
  localparam logic [StW-1:0] PS_RUNNING = 2'd2;

  localparam logic OP_ADC    = 1'b0;
  localparam logic OP_SENSOR = 1'b1;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_start;
    logic out_load;
  } pcet_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } pcet_sts_t;

endpackage

// ----- sv/pump_current_event_tracker_unit.sv -----
// each accepted input word passes through S_EXEC and then S_OUT on its way to the output word
// an event end with readings also passes through S_DIV for the bit-serial 48/32 divider
// the next input word is taken only after the current one is loaded into the output register
// a new input word is taken while the previous output word waits on m_axis_tready
// reset: asynchronous active-low, config to 2048/1000/100, event state cleared
module pump_current_event_tracker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcet_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [pcet_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // opcode, adc_value, current_ma, total_volume, time_ms, zero pad
  input  logic [pcet_pkg::InW-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pump_state, event_active, event_done, duration_ms, volume_pumped,
  // peak_current_ma, avg_current_ma, zero pad
  output logic [pcet_pkg::OutW-1:0]     m_axis_tdata
);

  pcet_pkg::pcet_cmd_t cmd;
  pcet_pkg::pcet_sts_t sts;

  pcet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcet_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

// ----- sv/pcet_div.sv -----
module pcet_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pcet_pkg::SumW-1:0]         dividend_i,
  input  logic [pcet_pkg::WordW-1:0]        divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [pcet_pkg::MaW-1:0]          quot_o
);

  localparam int unsigned CntW = $clog2(pcet_pkg::SumW);

  logic                         busy_q, done_q;
  logic [CntW-1:0]              cnt_q;
  logic [pcet_pkg::WordW-1:0]   rem_q, rem_d;
  logic [pcet_pkg::WordW-1:0]   dvs_q;
  logic [pcet_pkg::SumW-1:0]    quo_q, quo_d;
  logic [pcet_pkg::WordW:0]     shifted;
  logic                         fits;

  // one quotient bit a cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[pcet_pkg::SumW-1]};
    fits    = shifted >= {1'b0, dvs_q};
    if (fits) begin
      rem_d = pcet_pkg::WordW'(shifted - {1'b0, dvs_q});
    end else begin
      rem_d = shifted[pcet_pkg::WordW-1:0];
    end
    quo_d = {quo_q[pcet_pkg::SumW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(pcet_pkg::SumW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q[pcet_pkg::MaW-1:0];

endmodule

// ----- sv/pcet_dp.sv -----
module pcet_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcet_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [pcet_pkg::CfgW-1:0]     cfg_data_i,
  input  logic [pcet_pkg::InW-1:0]      in_data_i,
  input  logic                          m_ready_i,
  output logic                          m_valid_o,
  output logic [pcet_pkg::OutW-1:0]     m_data_o,
  input  pcet_pkg::pcet_cmd_t           cmd_i,
  output pcet_pkg::pcet_sts_t           sts_o
);

  logic [pcet_pkg::AdcW-1:0] thr_q;
  logic [pcet_pkg::MaW-1:0]  run_q, stby_q;

  logic                       in_op_q;
  logic [pcet_pkg::AdcW-1:0]  in_adc_q;
  logic [pcet_pkg::MaW-1:0]   in_ma_q;
  logic [pcet_pkg::WordW-1:0] in_vol_q, in_time_q;

  logic                       above_q, above_d;
  logic                       ev_on_q, ev_on_d;
  logic [pcet_pkg::StW-1:0]   state_q, state_d;
  logic [pcet_pkg::WordW-1:0] start_time_q, start_time_d;
  logic [pcet_pkg::WordW-1:0] start_vol_q, start_vol_d;
  logic [pcet_pkg::WordW-1:0] vol_delta_q, vol_delta_d;
  logic [pcet_pkg::MaW-1:0]   peak_q, peak_d;
  logic [pcet_pkg::SumW-1:0]  sum_q, sum_d;
  logic [pcet_pkg::WordW-1:0] count_q, count_d;
  logic                       ev_done;

  logic [pcet_pkg::StW-1:0]   res_state_q;
  logic                       res_active_q, res_done_q;
  logic [pcet_pkg::WordW-1:0] res_dur_q, res_vol_q;
  logic [pcet_pkg::MaW-1:0]   res_peak_q, res_avg_q;

  logic                       m_valid_q;
  logic [pcet_pkg::OutW-1:0]  m_data_q;

  logic                       adc_high;
  logic [pcet_pkg::StW-1:0]   cls;
  logic                       ev_start;
  logic                       div_busy, div_done;
  logic [pcet_pkg::MaW-1:0]   div_quot;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= pcet_pkg::AdcThrRst;
      run_q  <= pcet_pkg::RunLvlRst;
      stby_q <= pcet_pkg::StbyLvlRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcet_pkg::REG_ADC_THR:  thr_q  <= cfg_data_i[pcet_pkg::AdcW-1:0];
        pcet_pkg::REG_RUN_LVL:  run_q  <= cfg_data_i;
        pcet_pkg::REG_STBY_LVL: stby_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_op_q   <= in_data_i[0];
      in_adc_q  <= in_data_i[12:1];
      in_ma_q   <= in_data_i[28:13];
      in_vol_q  <= in_data_i[60:29];
      in_time_q <= in_data_i[92:61];
    end
  end

  assign adc_high = in_adc_q > thr_q;

  always_comb begin
    if (in_ma_q > run_q) begin
      cls = pcet_pkg::PS_RUNNING;
    end else if (in_ma_q > stby_q) begin
      cls = pcet_pkg::PS_STANDBY;
    end else begin
      cls = pcet_pkg::PS_OFF;
    end
  end

  assign ev_start = (cls == pcet_pkg::PS_RUNNING) && !ev_on_q && above_q;

  // event state update
  always_comb begin
    above_d      = above_q;
    ev_on_d      = ev_on_q;
    state_d      = state_q;
    start_time_d = start_time_q;
    start_vol_d  = start_vol_q;
    vol_delta_d  = vol_delta_q;
    peak_d       = peak_q;
    sum_d        = sum_q;
    count_d      = count_q;
    ev_done      = 1'b0;
    if (in_op_q == pcet_pkg::OP_ADC) begin
      if (adc_high != above_q) begin
        above_d = adc_high;
        if (!adc_high && ev_on_q) begin
          ev_done      = 1'b1;
          ev_on_d      = 1'b0;
          start_time_d = '0;
          start_vol_d  = '0;
          vol_delta_d  = '0;
          peak_d       = '0;
          sum_d        = '0;
          count_d      = '0;
        end
      end
    end else begin
      state_d = cls;
      if (ev_start) begin
        ev_on_d      = 1'b1;
        start_time_d = in_time_q;
        start_vol_d  = in_vol_q;
        vol_delta_d  = '0;
        peak_d       = '0;
        sum_d        = '0;
        count_d      = '0;
      end
      if (ev_on_d) begin
        if (in_ma_q > peak_d) begin
          peak_d = in_ma_q;
        end
        if (count_d != '1) begin
          sum_d   = sum_d + pcet_pkg::SumW'(in_ma_q);
          count_d = count_d + 1'b1;
        end
        vol_delta_d = in_vol_q - start_vol_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q      <= 1'b0;
      ev_on_q      <= 1'b0;
      state_q      <= pcet_pkg::PS_OFF;
      start_time_q <= '0;
      start_vol_q  <= '0;
      vol_delta_q  <= '0;
      peak_q       <= '0;
      sum_q        <= '0;
      count_q      <= '0;
    end else if (cmd_i.exec) begin
      above_q      <= above_d;
      ev_on_q      <= ev_on_d;
      state_q      <= state_d;
      start_time_q <= start_time_d;
      start_vol_q  <= start_vol_d;
      vol_delta_q  <= vol_delta_d;
      peak_q       <= peak_d;
      sum_q        <= sum_d;
      count_q      <= count_d;
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_state_q  <= state_d;
      res_active_q <= ev_on_d;
      res_done_q   <= ev_done;
      res_avg_q    <= '0;
      if (ev_on_d) begin
        res_dur_q  <= in_time_q - start_time_d;
        res_vol_q  <= vol_delta_d;
        res_peak_q <= peak_d;
      end else if (ev_done) begin
        res_dur_q  <= in_time_q - start_time_q;
        res_vol_q  <= vol_delta_q;
        res_peak_q <= peak_q;
      end else begin
        res_dur_q  <= '0;
        res_vol_q  <= '0;
        res_peak_q <= '0;
      end
    end else if (div_done) begin
      res_avg_q <= div_quot;
    end
  end

  pcet_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_data_q <= {(pcet_pkg::OutW - pcet_pkg::OutFieldsW)'(0), res_avg_q, res_peak_q,
                   res_vol_q, res_dur_q, res_done_q, res_active_q, res_state_q};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  assign sts_o.need_div = (in_op_q == pcet_pkg::OP_ADC) && (adc_high != above_q) &&
                          !adc_high && ev_on_q && (count_q != '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !m_valid_q || m_ready_i;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!m_valid_q || m_ready_i))
    else $error("output word overwritten");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_done_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[3]) |-> !m_data_q[2])
    else $error("ended event still marked active");

  a_count_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> ev_on_q)
    else $error("readings counted outside an event");

endmodule

// ----- sv/pcet_ctrl.sv -----
module pcet_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pcet_pkg::pcet_sts_t  sts_i,
  output pcet_pkg::pcet_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } ctrl_state_e;

  ctrl_state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= sts_i.need_div ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign cmd_o.load_in   = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec      = (state_q == S_EXEC);
  assign cmd_o.div_start = (state_q == S_EXEC) && sts_i.need_div;
  assign cmd_o.out_load  = (state_q == S_OUT) && sts_i.out_free;

  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> !cmd_o.exec)
    else $error("item executed twice");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> !in_ready_o)
    else $error("input taken during division");

  a_div_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_done) |=> (state_q == S_OUT))
    else $error("division result not delivered");

endmodule
